### rtl/cmgl_pkg.sv
// cmgl_pkg: types, constants and small tables for the month grid layout unit
// used by the front, queue and back modules; no dependencies

package cmgl_pkg;

   // job handed from the front to the back through the queue
   typedef struct packed {
      logic       bad;
      logic [4:0] dim;
      logic [2:0] start;
      logic [2:0] rows;
   } job_type;

   // one result word
   typedef struct packed {
      logic [4:0] day;
      logic [2:0] row;
      logic [2:0] col;
      logic [2:0] rows;
      logic       bad;
      logic       last;
   } result_type;

   // floor(v / 100) = (v * RECIP_100) >> RECIP_100_SHIFT for v < 16384
   localparam logic [12:0] RECIP_100       = 13'd5243;
   localparam int          RECIP_100_SHIFT = 19;
   // floor(v / 7) = (v * RECIP_7) >> RECIP_7_SHIFT for v < 32768
   localparam logic [17:0] RECIP_7         = 18'd149797;
   localparam int          RECIP_7_SHIFT   = 20;

   localparam logic [3:0] MONTH_FEB     = 4'd2;
   localparam logic [3:0] MONTH_MAR     = 4'd3;
   localparam logic [4:0] DAYS_LEAP_FEB = 5'd29;
   localparam logic [2:0] LAST_COLUMN   = 3'd6;

   // configuration register index (byte address bit 2)
   localparam logic CSR_WEEK_START = 1'b0;

   function automatic logic [2:0] month_offset(input logic [3:0] month);
      logic [2:0] off;
      unique case (month)
         4'd1:    off = 3'd0;
         4'd2:    off = 3'd3;
         4'd3:    off = 3'd2;
         4'd4:    off = 3'd5;
         4'd5:    off = 3'd0;
         4'd6:    off = 3'd3;
         4'd7:    off = 3'd5;
         4'd8:    off = 3'd1;
         4'd9:    off = 3'd4;
         4'd10:   off = 3'd6;
         4'd11:   off = 3'd2;
         4'd12:   off = 3'd4;
         default: off = 3'd0;
      endcase
      return off;
   endfunction

   function automatic logic [4:0] month_length(input logic [3:0] month);
      logic [4:0] len;
      unique case (month)
         4'd2:                   len = 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
         default:                len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

### rtl/cmgl_front.sv
// cmgl_front: takes a month and year, finds month length, weekday of the 1st
// and rows used, and pushes one job into the job queue
// depends on cmgl_pkg

module cmgl_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  logic [3:0]        month_number,
   input  logic [13:0]       year_number,
   input  logic              week_starts_monday,
   output logic              job_push,
   output cmgl_pkg::job_type job_data,
   input  logic              job_full
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MULY = 3'd1;
   localparam logic [2:0] ST_SUM  = 3'd2;
   localparam logic [2:0] ST_MUL7 = 3'd3;
   localparam logic [2:0] ST_FIN  = 3'd4;

   localparam int RECIP_100_SHIFT_HI = cmgl_pkg::RECIP_100_SHIFT + 7;

   logic [2:0]  state_ff, state_in;
   logic [3:0]  month_ff;
   logic [13:0] year_ff;
   logic [13:0] y_ff;
   logic        bad_ff;
   logic [26:0] prod_ff;
   logic [14:0] sum_ff;
   logic [32:0] prod7_ff;
   logic        leap_ff;

   logic        accept;
   logic        bad_now;
   logic [13:0] mul_op;
   logic [7:0]  q100;
   logic [14:0] sum_in;
   logic        rem100_zero;
   logic        leap_in;
   logic [11:0] q7;
   logic [14:0] rem7;
   logic [2:0]  wd;
   logic [2:0]  start;
   logic [4:0]  dim;
   logic [5:0]  span;
   logic [2:0]  rows;

   assign full    = (state_ff != ST_IDLE);
   assign accept  = push && !full;
   assign bad_now = (month_number == 4'd0) || (month_number > 4'd12) || (year_number == 14'd0);

   // shared constant multiplier: shifted year first, then the year itself
   assign mul_op = (state_ff == ST_MULY) ? y_ff : year_ff;
   assign q100   = prod_ff[RECIP_100_SHIFT_HI:cmgl_pkg::RECIP_100_SHIFT];

   // sakamoto sum before mod 7
   assign sum_in = 15'(y_ff) + 15'(y_ff[13:2]) - 15'(q100) + 15'(q100[7:2])
                   + 15'(cmgl_pkg::month_offset(month_ff)) + 15'd1;

   // here prod_ff holds year * recip
   assign rem100_zero = (15'(year_ff) == 15'(q100) * 15'd100);
   assign leap_in     = (year_ff[1:0] == 2'd0) && (!rem100_zero || (q100[1:0] == 2'd0));

   assign q7   = prod7_ff[cmgl_pkg::RECIP_7_SHIFT + 11:cmgl_pkg::RECIP_7_SHIFT];
   assign rem7 = sum_ff - 15'(q7) * 15'd7;
   assign wd   = rem7[2:0];

   always_comb begin
      if (!week_starts_monday) begin
         start = wd;
      end else if (wd == 3'd0) begin
         start = cmgl_pkg::LAST_COLUMN;
      end else begin
         start = wd - 3'd1;
      end
      if ((month_ff == cmgl_pkg::MONTH_FEB) && leap_ff) begin
         dim = cmgl_pkg::DAYS_LEAP_FEB;
      end else begin
         dim = cmgl_pkg::month_length(month_ff);
      end
      span = 6'(start) + 6'(dim) + 6'd6;
      if (span >= 6'd42) begin
         rows = 3'd6;
      end else if (span >= 6'd35) begin
         rows = 3'd5;
      end else begin
         rows = 3'd4;
      end
   end

   always_comb begin
      job_push = (state_ff == ST_FIN) && !job_full;
      if (bad_ff) begin
         job_data = '{bad: 1'b1, dim: 5'd0, start: 3'd0, rows: 3'd0};
      end else begin
         job_data = '{bad: 1'b0, dim: dim, start: start, rows: rows};
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = bad_now ? ST_FIN : ST_MULY;
            end
         end
         ST_MULY: state_in = ST_SUM;
         ST_SUM:  state_in = ST_MUL7;
         ST_MUL7: state_in = ST_FIN;
         ST_FIN: begin
            if (!job_full) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         month_ff <= month_number;
         year_ff  <= year_number;
         bad_ff   <= bad_now;
         y_ff     <= (month_number < cmgl_pkg::MONTH_MAR) ? year_number - 14'd1 : year_number;
      end
      if ((state_ff == ST_MULY) || (state_ff == ST_SUM)) begin
         prod_ff <= 27'(mul_op) * 27'(cmgl_pkg::RECIP_100);
      end
      if (state_ff == ST_SUM) begin
         sum_ff <= sum_in;
      end
      if (state_ff == ST_MUL7) begin
         prod7_ff <= 33'(sum_ff) * 33'(cmgl_pkg::RECIP_7);
         leap_ff  <= leap_in;
      end
   end

endmodule

### rtl/cmgl_job_queue.sv
// cmgl_job_queue: short first-in first-out queue of jobs between front and back
// depends on cmgl_pkg

module cmgl_job_queue #(
   parameter int DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  cmgl_pkg::job_type push_data,
   output logic              full,
   input  logic              pop,
   output cmgl_pkg::job_type pop_data,
   output logic              empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmgl_pkg::job_type entries_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/cmgl_back.sv
// cmgl_back: walks one job day by day and fills the result register
// depends on cmgl_pkg

module cmgl_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 job_empty,
   input  cmgl_pkg::job_type    job_data,
   output logic                 job_pop,
   output logic                 out_valid,
   output cmgl_pkg::result_type out_data,
   input  logic                 out_pop
);

   logic                 active_ff, active_in;
   cmgl_pkg::job_type    job_ff;
   logic [4:0]           day_ff, day_in;
   logic [2:0]           row_ff, row_in;
   logic [2:0]           col_ff, col_in;
   logic                 out_valid_ff, out_valid_in;
   cmgl_pkg::result_type out_ff, out_in;
   logic                 out_free;
   logic                 emit;
   logic                 last;

   assign out_free  = !out_valid_ff || out_pop;
   assign emit      = out_free && active_ff;
   assign job_pop   = !active_ff && !job_empty;
   assign last      = job_ff.bad || (day_ff == job_ff.dim);
   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;

   always_comb begin
      active_in    = active_ff;
      day_in       = day_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !out_pop;
      if (job_pop) begin
         active_in = 1'b1;
         day_in    = 5'd1;
         row_in    = 3'd0;
         col_in    = job_data.start;
      end else if (emit) begin
         out_valid_in = 1'b1;
         if (job_ff.bad) begin
            out_in = '{day: 5'd0, row: 3'd0, col: 3'd0, rows: 3'd0, bad: 1'b1, last: 1'b1};
         end else begin
            out_in = '{day: day_ff, row: row_ff, col: col_ff, rows: job_ff.rows,
                       bad: 1'b0, last: last};
         end
         if (last) begin
            active_in = 1'b0;
         end else begin
            day_in = day_ff + 5'd1;
            // wrap to the next week row after the last column
            if (col_ff == cmgl_pkg::LAST_COLUMN) begin
               col_in = 3'd0;
               row_in = row_ff + 3'd1;
            end else begin
               col_in = col_ff + 3'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (job_pop) begin
         job_ff <= job_data;
      end
      day_ff <= day_in;
      row_ff <= row_in;
      col_ff <= col_in;
      out_ff <= out_in;
   end

endmodule

### rtl/calendar_month_grid_layout_unit.sv
// calendar_month_grid_layout_unit: top level, configuration register and the
// front / job queue / back chain; depends on cmgl_pkg, cmgl_front,
// cmgl_job_queue and cmgl_back
//
//   channel   ports                                  handshake
//   -------   ------------------------------------   ------------------------
//   request   req_month_number, req_year_number      push / full
//   response  rsp_day_of_month .. rsp_last_day       empty / pop
//   config    psel penable pwrite paddr pwdata ...   apb write, pready high
//
// the front steps through multiply, sum, mod-7 multiply and finish for each accepted
// month (straight to finish for a bad month or year), making two passes through the
// shared reciprocal multiplier; the back gives one word per cycle while pop keeps the
// result register free, after it loads each job from the queue.
// synchronous reset clears the front, the queue, the week start and the output valid flag.
// the front keeps accepting while the back waits on pop, until the queue is full
// and the front holds one finished job.

module calendar_month_grid_layout_unit #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [3:0]  req_month_number,
   input  logic [13:0] req_year_number,
   output logic        empty,
   input  logic        pop,
   output logic [4:0]  rsp_day_of_month,
   output logic [2:0]  rsp_week_row,
   output logic [2:0]  rsp_weekday_column,
   output logic [2:0]  rsp_rows_used,
   output logic        rsp_bad_input,
   output logic        rsp_last_day,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic                 week_start_ff, week_start_in;
   logic                 csr_write;
   logic                 job_push, job_full, job_pop, job_empty;
   cmgl_pkg::job_type    push_job, pop_job;
   logic                 out_valid;
   cmgl_pkg::result_type out_data;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && (paddr[2] == cmgl_pkg::CSR_WEEK_START);
   assign prdata    = (paddr[2] == cmgl_pkg::CSR_WEEK_START) ? 32'(week_start_ff) : 32'd0;

   always_comb begin
      week_start_in = week_start_ff;
      if (csr_write) begin
         week_start_in = pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         week_start_ff <= 1'b0;
      end else begin
         week_start_ff <= week_start_in;
      end
   end

   cmgl_front u_front (
      .clock              (clock),
      .reset              (reset),
      .push               (push),
      .full               (full),
      .month_number       (req_month_number),
      .year_number        (req_year_number),
      .week_starts_monday (week_start_ff),
      .job_push           (job_push),
      .job_data           (push_job),
      .job_full           (job_full)
   );

   cmgl_job_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (push_job),
      .full      (job_full),
      .pop       (job_pop),
      .pop_data  (pop_job),
      .empty     (job_empty)
   );

   cmgl_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_empty (job_empty),
      .job_data  (pop_job),
      .job_pop   (job_pop),
      .out_valid (out_valid),
      .out_data  (out_data),
      .out_pop   (pop)
   );

   assign empty              = !out_valid;
   assign rsp_day_of_month   = out_data.day;
   assign rsp_week_row       = out_data.row;
   assign rsp_weekday_column = out_data.col;
   assign rsp_rows_used      = out_data.rows;
   assign rsp_bad_input      = out_data.bad;
   assign rsp_last_day       = out_data.last;

`ifndef SYNTH
   a_reset_empty: assert property (@(posedge clock) reset |=> empty)
      else $error("result word present right after reset");

   a_bad_word: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_bad_input) |-> (rsp_last_day && rsp_day_of_month == 5'd0
                                     && rsp_rows_used == 3'd0))
      else $error("bad input word not a single zeroed last word");

   a_rows_range: assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_bad_input) |-> (rsp_rows_used >= 3'd4 && rsp_rows_used <= 3'd6
                                      && rsp_weekday_column <= 3'd6 && rsp_week_row <= 3'd5))
      else $error("grid position or row count out of range");

   a_month_end: assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_bad_input && rsp_last_day) |-> (rsp_day_of_month >= 5'd28))
      else $error("month ended before day 28");

   a_day_step: assert property (@(posedge clock) disable iff (reset)
      (!empty && pop && !rsp_last_day && !rsp_bad_input) |=>
         (empty || rsp_day_of_month == $past(rsp_day_of_month) + 5'd1))
      else $error("day numbers not consecutive");
`endif

endmodule

### dv/calendar_month_grid_layout_unit_test.sv
// calendar_month_grid_layout_unit_test: self-checking bench for the month grid unit,
// with a scoreboard that predicts every day word of a month from its month and year
// depends on cmgl_pkg and calendar_month_grid_layout_unit

module calendar_month_grid_layout_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          CYCLE_LIMIT     = 600000;
   localparam int          PHASE_COUNT     = 6;
   localparam int          MONTHS_PER_PHASE = 48;
   localparam int          SETTLE_CYCLES   = 8;
   localparam logic [2:0]  WEEK_START_ADDR = 3'd0;
   localparam logic [2:0]  UNMAPPED_ADDR   = 3'd4;

   // predicts the day words of each accepted month and checks them in order
   class month_grid_scoreboard;
      cmgl_pkg::result_type days_due[$];
      int          errors = 0;
      int unsigned first_offset[12] = '{0, 3, 2, 5, 0, 3, 5, 1, 4, 6, 2, 4};
      int unsigned base_length[12]  = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

      task report_mismatch(input string msg);
         $display("mismatch: %s", msg);
         errors++;
      endtask

      function int pending();
         return days_due.size();
      endfunction

      function void note_month(input logic [3:0] month, input logic [13:0] year,
                               input bit monday);
         int unsigned y;
         int unsigned start;
         int unsigned dim;
         int unsigned rows;
         int unsigned slot;
         bit          leap;
         cmgl_pkg::result_type w;
         if (month < 4'd1 || month > 4'd12 || year == 14'd0) begin
            w = '0;
            w.bad = 1'b1;
            w.last = 1'b1;
            days_due.push_back(w);
            return;
         end
         y = year;
         // jan and feb count as months of the previous year
         if (month < 4'd3) y = y - 1;
         start = (y + y / 4 - y / 100 + y / 400 + first_offset[month - 1] + 1) % 7;
         if (monday) start = (start + 6) % 7;
         leap = (year % 400 == 0) || (year % 4 == 0 && year % 100 != 0);
         dim = base_length[month - 1];
         if (month == 4'd2 && leap) dim = 29;
         rows = (start + dim + 6) / 7;
         for (int unsigned d = 0; d < dim; d++) begin
            slot = start + d;
            w.day  = 5'(d + 1);
            w.row  = 3'(slot / 7);
            w.col  = 3'(slot % 7);
            w.rows = 3'(rows);
            w.bad  = 1'b0;
            w.last = (d + 1 == dim);
            days_due.push_back(w);
         end
      endfunction

      task check_word(input cmgl_pkg::result_type got);
         cmgl_pkg::result_type want;
         if (days_due.size() == 0) begin
            report_mismatch($sformatf("word day=%0d with nothing expected", got.day));
            return;
         end
         want = days_due.pop_front();
         if (got.day !== want.day)
            report_mismatch($sformatf("day_of_month %0d, want %0d", got.day, want.day));
         if (got.row !== want.row)
            report_mismatch($sformatf("week_row %0d, want %0d (day %0d)",
                                      got.row, want.row, want.day));
         if (got.col !== want.col)
            report_mismatch($sformatf("weekday_column %0d, want %0d (day %0d)",
                                      got.col, want.col, want.day));
         if (got.rows !== want.rows)
            report_mismatch($sformatf("rows_used %0d, want %0d (day %0d)",
                                      got.rows, want.rows, want.day));
         if (got.bad !== want.bad)
            report_mismatch($sformatf("bad_input %0b, want %0b (day %0d)",
                                      got.bad, want.bad, want.day));
         if (got.last !== want.last)
            report_mismatch($sformatf("last_day %0b, want %0b (day %0d)",
                                      got.last, want.last, want.day));
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   logic [3:0]  req_month_number = '0;
   logic [13:0] req_year_number = '0;
   logic        empty;
   logic        pop = 1'b0;
   logic [4:0]  rsp_day_of_month;
   logic [2:0]  rsp_week_row;
   logic [2:0]  rsp_weekday_column;
   logic [2:0]  rsp_rows_used;
   logic        rsp_bad_input;
   logic        rsp_last_day;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   month_grid_scoreboard grid = new();
   bit week_monday = 1'b0;
   bit steady = 1'b0;
   int cycles = 0;

   calendar_month_grid_layout_unit dut (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_month_number(req_month_number),
      .req_year_number(req_year_number),
      .empty(empty),
      .pop(pop),
      .rsp_day_of_month(rsp_day_of_month),
      .rsp_week_row(rsp_week_row),
      .rsp_weekday_column(rsp_weekday_column),
      .rsp_rows_used(rsp_rows_used),
      .rsp_bad_input(rsp_bad_input),
      .rsp_last_day(rsp_last_day),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // push stays high across back-to-back words, lowered only for a gap
   task automatic push_month(input logic [3:0] month, input logic [13:0] year);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push <= 1'b1;
      req_month_number <= month;
      req_year_number <= year;
      do @(posedge clock); while (full);
      grid.note_month(month, year, week_monday);
   endtask

   task automatic push_random_month();
      int          kind;
      int          pick;
      logic [3:0]  month;
      logic [13:0] year;
      kind = $urandom_range(0, 99);
      if (kind < 6) begin
         pick = $urandom_range(13, 16);
         month = (pick == 16) ? 4'd0 : 4'(pick);
         year = 14'($urandom_range(0, 16383));
      end else if (kind < 9) begin
         month = 4'($urandom_range(1, 12));
         year = 14'd0;
      end else begin
         month = 4'($urandom_range(1, 12));
         pick = $urandom_range(0, 9);
         case (pick)
            0: year = 14'($urandom_range(10000, 16383));
            1: year = 14'(100 * $urandom_range(1, 163));
            2: year = 14'(400 * $urandom_range(1, 40));
            3: year = 14'(4 * $urandom_range(1, 2500));
            default: year = 14'($urandom_range(1, 9999));
         endcase
      end
      push_month(month, year);
   endtask

   task automatic wait_drained();
      push <= 1'b0;
      while (grid.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_read(input logic [2:0] addr, output logic [31:0] data);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= addr;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      data = prdata;
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // result side: random pop gaps, one check per accepted word
   initial begin
      int                   gap;
      cmgl_pkg::result_type got;
      wait (!reset);
      @(posedge clock);
      forever begin
         gap = steady ? 0 : $urandom_range(0, 7);
         if (gap > 0) begin
            pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         pop <= 1'b1;
         do @(posedge clock); while (empty);
         got.day  = rsp_day_of_month;
         got.row  = rsp_week_row;
         got.col  = rsp_weekday_column;
         got.rows = rsp_rows_used;
         got.bad  = rsp_bad_input;
         got.last = rsp_last_day;
         grid.check_word(got);
      end
   end

   initial begin
      logic [31:0] readback;
      logic [31:0] wdata;
      bit          monday;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed months under the reset week start (sunday first)
      push_month(4'd0, 14'd2024);
      push_month(4'd13, 14'd2024);
      push_month(4'd14, 14'd16383);
      push_month(4'd15, 14'd1);
      push_month(4'd5, 14'd0);
      push_month(4'd1, 14'd1);
      push_month(4'd2, 14'd1);
      push_month(4'd3, 14'd1);
      push_month(4'd2, 14'd2000);
      push_month(4'd2, 14'd1900);
      push_month(4'd2, 14'd2024);
      push_month(4'd2, 14'd2023);
      push_month(4'd2, 14'd2015);
      push_month(4'd8, 14'd2020);
      push_month(4'd12, 14'd9999);
      push_month(4'd2, 14'd10000);
      push_month(4'd12, 14'd16383);
      for (int m = 1; m <= 12; m++) push_month(4'(m), 14'd2025);

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         wait_drained();
         monday = (phase % 2 == 0);
         wdata = {31'($urandom), monday};
         csr_write(WEEK_START_ADDR, wdata);
         week_monday = monday;
         // a write past the register list must leave the week start alone
         if (phase == 3) csr_write(UNMAPPED_ADDR, ~wdata);
         csr_read(WEEK_START_ADDR, readback);
         if (readback !== {31'd0, week_monday})
            grid.report_mismatch($sformatf("week start reads %h, want %0b",
                                           readback, week_monday));
         steady = (phase == 2);
         // a four-row february for the current week start
         push_month(4'd2, monday ? 14'd2021 : 14'd2015);
         for (int i = 0; i < MONTHS_PER_PHASE; i++) begin
            // hold off the sender once mid-phase until the back drains
            if (phase == 1 && i == MONTHS_PER_PHASE / 2) wait_drained();
            push_random_month();
         end
      end

      wait_drained();
      repeat (40) @(posedge clock);
      if (grid.errors == 0 && grid.pending() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
